// ----- sv/cicp_pkg.sv -----
`timescale 1ns / 1ps

package cicp_pkg;

	// item opcodes
	localparam logic [2:0] OP_PORT_WRITE = 3'd0;
	localparam logic [2:0] OP_PORT_READ  = 3'd1;
	localparam logic [2:0] OP_RAISE_IRQ  = 3'd2;
	localparam logic [2:0] OP_HOST_MASK  = 3'd3;
	localparam logic [2:0] OP_DELIVER    = 3'd4;
	localparam logic [2:0] OP_IF_CHANGE  = 3'd5;

	// reset values
	localparam logic [7:0] MASTER_BASE_RST = 8'h08;
	localparam logic [7:0] SLAVE_BASE_RST  = 8'h70;
	localparam logic [7:0] MASK_RST        = 8'hFF;
	localparam logic [7:0] READ_NONE       = 8'hFF;

	// command byte decode
	localparam logic [4:0] OCW2_EOI      = 5'b00100;
	localparam logic [4:0] OCW2_EOI_SPEC = 5'b01100;
	localparam logic [1:0] CMD_OCW2      = 2'b00;
	localparam logic [1:0] CMD_OCW3      = 2'b01;

	// initialization-word and read-select state per controller
	typedef enum logic [5:0] {
		MODE_NORMAL = 6'b000001,
		MODE_ICW2   = 6'b000010,
		MODE_ICW3   = 6'b000100,
		MODE_ICW4   = 6'b001000,
		MODE_RD_IRR = 6'b010000,
		MODE_RD_ISR = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [1:0]  port_select;
		logic        access_is_byte;
		logic [7:0]  write_data;
		logic [3:0]  irq_line;
		logic [15:0] mask_bits;
		logic        mask_set;
		logic        cpu_if;
		logic        in_v86;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_taken;
		logic [7:0] int_vector;
		logic       delivery_armed;
		logic       wake_request;
	} rsp_item_t;

	// lowest set line, 7 when none is set
	function automatic logic [2:0] lowest_line(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/cicp_ctrl.sv -----
`timescale 1ns / 1ps

module cicp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  cicp_pkg::req_item_t  item,
	output cicp_pkg::rsp_item_t  result
);

	cicp_pkg::mode_t mode_q [2];
	logic            want_q [2];
	logic [7:0]      irr_q  [2];
	logic [7:0]      isr_q  [2];
	logic [7:0]      mask_q [2];
	logic [7:0]      base_q [2];
	logic [7:0]      link_q [2];
	logic            armed_q;

	cicp_pkg::mode_t mode_d [2];
	logic            want_d [2];
	logic [7:0]      irr_d  [2];
	logic [7:0]      isr_d  [2];
	logic [7:0]      mask_d [2];
	logic [7:0]      base_d [2];
	logic [7:0]      link_d [2];
	logic            armed_d;

	logic       c;
	logic [7:0] v;
	logic [2:0] irq;
	logic [2:0] sl;
	logic [7:0] irq_bit;
	logic [7:0] casc_bit;

	assign c        = item.port_select[1];
	assign v        = item.write_data;
	assign irq      = cicp_pkg::lowest_line(irr_q[0]);
	assign sl       = cicp_pkg::lowest_line(irr_q[1]);
	assign irq_bit  = 8'b1 << irq;
	assign casc_bit = 8'b1 << link_q[1][2:0];

	// next state and result for the item in hand
	always_comb begin
		mode_d  = mode_q;
		want_d  = want_q;
		irr_d   = irr_q;
		isr_d   = isr_q;
		mask_d  = mask_q;
		base_d  = base_q;
		link_d  = link_q;
		armed_d = armed_q;
		result  = '0;
		case (item.opcode)
			cicp_pkg::OP_PORT_WRITE: begin
				if (item.access_is_byte) begin
					if (!item.port_select[0]) begin
						// command port, only acts in normal mode
						if (mode_q[c] == cicp_pkg::MODE_NORMAL) begin
							if (v[4]) begin
								mode_d[c] = cicp_pkg::MODE_ICW2;
								want_d[c] = v[0];
							end else if (v[4:3] == cicp_pkg::CMD_OCW2) begin
								if (v[7:3] inside {cicp_pkg::OCW2_EOI,
								                   cicp_pkg::OCW2_EOI_SPEC}) begin
									isr_d[c] = '0;
									if (item.cpu_if && irr_q[0] != 8'h00) begin
										armed_d = 1'b1;
									end
								end
							end else if (v[4:3] == cicp_pkg::CMD_OCW3) begin
								if (v[1]) begin
									mode_d[c] = v[0] ? cicp_pkg::MODE_RD_IRR
									                 : cicp_pkg::MODE_RD_ISR;
								end
							end
						end
					end else begin
						// data port
						case (mode_q[c])
							cicp_pkg::MODE_NORMAL: begin
								mask_d[c] = v;
							end
							cicp_pkg::MODE_ICW2: begin
								base_d[c] = {v[7:3], 3'b000};
								mode_d[c] = cicp_pkg::MODE_ICW3;
							end
							cicp_pkg::MODE_ICW3: begin
								link_d[c] = c ? {5'b00000, v[2:0]} : v;
								mode_d[c] = want_q[c] ? cicp_pkg::MODE_ICW4
								                      : cicp_pkg::MODE_NORMAL;
							end
							cicp_pkg::MODE_ICW4: begin
								mode_d[c] = cicp_pkg::MODE_NORMAL;
							end
							default: begin
							end
						endcase
					end
				end
			end
			cicp_pkg::OP_PORT_READ: begin
				if (!item.access_is_byte) begin
					result.read_data = cicp_pkg::READ_NONE;
				end else if (item.port_select[0]) begin
					result.read_data = mask_q[c];
				end else begin
					if (mode_q[c] == cicp_pkg::MODE_RD_ISR) begin
						result.read_data = isr_q[c];
					end else if (mode_q[c] == cicp_pkg::MODE_RD_IRR) begin
						result.read_data = irr_q[c];
					end else begin
						result.read_data = cicp_pkg::READ_NONE;
					end
					mode_d[c] = cicp_pkg::MODE_NORMAL;
				end
			end
			cicp_pkg::OP_RAISE_IRQ: begin
				if (item.irq_line[3]) begin
					irr_d[1] = (irr_q[1] | (8'b1 << item.irq_line[2:0])) & ~mask_q[1];
					irr_d[0] = (irr_q[0] | casc_bit) & ~mask_q[0];
				end else begin
					irr_d[0] = (irr_q[0] | (8'b1 << item.irq_line[2:0])) & ~mask_q[0];
				end
				if (item.cpu_if) begin
					result.wake_request = 1'b1;
					armed_d             = 1'b1;
				end
			end
			cicp_pkg::OP_HOST_MASK: begin
				if (item.mask_set) begin
					mask_d[0] = mask_q[0] | item.mask_bits[7:0];
					mask_d[1] = mask_q[1] | item.mask_bits[15:8];
				end else begin
					mask_d[0] = mask_q[0] & ~item.mask_bits[7:0];
					mask_d[1] = mask_q[1] & ~item.mask_bits[15:8];
				end
			end
			cicp_pkg::OP_DELIVER: begin
				if (armed_q) begin
					if (item.in_v86 && item.cpu_if && isr_q[0] == 8'h00 &&
					    irr_q[0] != 8'h00) begin
						irr_d[0] = irr_q[0] & ~irq_bit;
						isr_d[0] = irq_bit;
						if (link_q[0] == irq_bit) begin
							// cascade through the slave
							irr_d[1] = irr_q[1] & ~(8'b1 << sl);
							isr_d[1] = 8'b1 << sl;
							if (irr_d[1] != 8'h00) begin
								irr_d[0] = (irr_d[0] | casc_bit) & ~mask_q[0];
							end
							result.int_vector = base_q[1] + {5'b00000, sl};
						end else begin
							result.int_vector = base_q[0] + {5'b00000, irq};
						end
						result.int_taken = 1'b1;
					end
					if (irr_d[0] == 8'h00) begin
						armed_d = 1'b0;
					end
				end
			end
			cicp_pkg::OP_IF_CHANGE: begin
				if (item.cpu_if) begin
					if (irr_q[0] != 8'h00) begin
						armed_d = 1'b1;
					end
				end else begin
					armed_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
		result.delivery_armed = armed_d;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				mode_q[k] <= cicp_pkg::MODE_NORMAL;
				want_q[k] <= 1'b0;
				irr_q[k]  <= '0;
				isr_q[k]  <= '0;
				mask_q[k] <= cicp_pkg::MASK_RST;
				link_q[k] <= '0;
			end
			base_q[0] <= cicp_pkg::MASTER_BASE_RST;
			base_q[1] <= cicp_pkg::SLAVE_BASE_RST;
			armed_q   <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			want_q  <= want_d;
			irr_q   <= irr_d;
			isr_q   <= isr_d;
			mask_q  <= mask_d;
			base_q  <= base_d;
			link_q  <= link_d;
			armed_q <= armed_d;
		end
	end

endmodule

// ----- sv/cascaded_interrupt_controller_pair_core.sv -----
`timescale 1ns / 1ps

// an accepted item waits in the input register and its result item is captured in the result register
// throughput: one item per cycle while rsp_ready keeps the result register draining; the controller state updates
// in a single pass between the input register and the result register
// reset: both controllers in normal mode, requests and service bits clear, masks all
// ones, bases 0x08 and 0x70, delivery disarmed, both registers empty
module cascaded_interrupt_controller_pair_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  cicp_pkg::req_item_t  req_item,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output cicp_pkg::rsp_item_t  rsp_item
);

	cicp_pkg::req_item_t item_s1;
	logic                vld_s1;
	cicp_pkg::rsp_item_t rsp_q;
	logic                rsp_vld_q;
	cicp_pkg::rsp_item_t result;
	logic                advance;

	// the item in the input register moves on when the result slot frees up
	assign advance   = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || advance;
	assign rsp_valid = rsp_vld_q;
	assign rsp_item  = rsp_q;

	cicp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

endmodule
